>>> rtl/hpss_pkg.sv
// ----------------------------------------------------------------------------
// hpss_pkg
// Shared types and constants for the host[:port] string splitter.
// ----------------------------------------------------------------------------
package hpss_pkg;

    // Longest string handled; MAX_LEN bytes or more is reported as too long.
    localparam int MAX_LEN = 1024;
    // Position counter must hold MAX_LEN itself (saturation value).
    localparam int POS_W   = $clog2(MAX_LEN + 1);
    // Width of the offset and count fields of a result item.
    localparam int FIELD_W = 10;

    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_LBR   = 8'h5B;   // '['
    localparam logic [7:0] CHR_RBR   = 8'h5D;   // ']'
    localparam logic [7:0] CHR_COLON = 8'h3A;   // ':'

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SYNTAX   = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    typedef enum logic [2:0] {
        MODE_START    = 3'd0,
        MODE_BR_HOST  = 3'd1,
        MODE_BR_AFTER = 3'd2,
        MODE_BR_COLON = 3'd3,
        MODE_BR_PORT  = 3'd4,
        MODE_PLAIN    = 3'd5
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic [POS_W-1:0]   position;
        logic [POS_W-1:0]   colons_seen;
        logic [POS_W-1:0]   last_colon_pos;
        logic [POS_W-1:0]   close_bracket_pos;
        logic               error_flag;
        logic               too_long_flag;
    } t_parse_state;

    typedef struct packed {
        logic [1:0]         status;
        logic               host_start;
        logic [FIELD_W-1:0] host_len;
        logic [FIELD_W-1:0] port_start;
        logic [FIELD_W-1:0] port_len;
        logic               is_bracketed;
        logic [FIELD_W-1:0] colon_count;
    } t_result;

endpackage

>>> rtl/hpss_char_if.sv
// ----------------------------------------------------------------------------
// hpss_char_if
// Byte channel: one string byte per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hpss_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

>>> rtl/hpss_split_if.sv
// ----------------------------------------------------------------------------
// hpss_split_if
// Result channel: one split result per terminated string, valid/ready.
// ----------------------------------------------------------------------------
interface hpss_split_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       host_start;
    logic [9:0] host_len;
    logic [9:0] port_start;
    logic [9:0] port_len;
    logic       is_bracketed;
    logic [9:0] colon_count;

    modport source (
        output valid, output status, output host_start, output host_len,
        output port_start, output port_len, output is_bracketed,
        output colon_count, input ready
    );
    modport sink (
        input valid, input status, input host_start, input host_len,
        input port_start, input port_len, input is_bracketed,
        input colon_count, output ready
    );
endinterface

>>> rtl/hpss_result.sv
// ----------------------------------------------------------------------------
// hpss_result
// Turns the parse state at the terminating NUL into a result item.
// ----------------------------------------------------------------------------
module hpss_result (
    input  hpss_pkg::t_parse_state i_state,
    output hpss_pkg::t_result      o_result
);

    logic [hpss_pkg::FIELD_W-1:0] w_len;
    logic [hpss_pkg::FIELD_W-1:0] w_cbp;
    logic [hpss_pkg::FIELD_W-1:0] w_lcp;

    // Offsets and counts wrap to field width, so reduce first then add.
    assign w_len = hpss_pkg::FIELD_W'(i_state.position);
    assign w_cbp = hpss_pkg::FIELD_W'(i_state.close_bracket_pos);
    assign w_lcp = hpss_pkg::FIELD_W'(i_state.last_colon_pos);

    always_comb begin
        o_result = '0;
        o_result.status = hpss_pkg::ST_SYNTAX;
        if (i_state.too_long_flag) begin
            o_result.status = hpss_pkg::ST_TOO_LONG;
        end else if (!i_state.error_flag) begin
            case (i_state.mode)
                hpss_pkg::MODE_BR_AFTER: begin
                    o_result.status       = hpss_pkg::ST_OK;
                    o_result.host_start   = 1'b1;
                    o_result.is_bracketed = 1'b1;
                    o_result.host_len     = w_cbp - hpss_pkg::FIELD_W'(1);
                    o_result.port_start   = w_cbp + hpss_pkg::FIELD_W'(1);
                end
                hpss_pkg::MODE_BR_PORT: begin
                    o_result.status       = hpss_pkg::ST_OK;
                    o_result.host_start   = 1'b1;
                    o_result.is_bracketed = 1'b1;
                    o_result.host_len     = w_cbp - hpss_pkg::FIELD_W'(1);
                    o_result.port_start   = w_cbp + hpss_pkg::FIELD_W'(2);
                    o_result.port_len     = w_len - w_cbp - hpss_pkg::FIELD_W'(2);
                end
                hpss_pkg::MODE_PLAIN: begin
                    if (i_state.colons_seen == hpss_pkg::POS_W'(1)) begin
                        // host:port, both halves non-empty
                        if (i_state.last_colon_pos != '0 &&
                            i_state.last_colon_pos + hpss_pkg::POS_W'(1)
                                != i_state.position) begin
                            o_result.status      = hpss_pkg::ST_OK;
                            o_result.host_len    = w_lcp;
                            o_result.port_start  = w_lcp + hpss_pkg::FIELD_W'(1);
                            o_result.port_len    = w_len - w_lcp
                                                   - hpss_pkg::FIELD_W'(1);
                            o_result.colon_count = hpss_pkg::FIELD_W'(1);
                        end
                    end else begin
                        // no colon or several: all host
                        o_result.status      = hpss_pkg::ST_OK;
                        o_result.host_len    = w_len;
                        o_result.port_start  = w_len;
                        o_result.colon_count =
                            hpss_pkg::FIELD_W'(i_state.colons_seen);
                    end
                end
                default: begin
                    o_result.status = hpss_pkg::ST_SYNTAX;
                end
            endcase
        end
    end

endmodule

>>> rtl/host_port_string_splitter.sv
// ----------------------------------------------------------------------------
// host_port_string_splitter
// Splits a NUL-terminated host[:port] byte stream into host and port parts.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake     payload
//  i_char    in   valid/ready   char_code[7:0]
//  o_split   out  valid/ready   status, host_start, host_len, port_start,
//                               port_len, is_bracketed, colon_count
//
//  One byte is accepted per cycle while i_char.ready is high. Non-NUL bytes
//  update the parse state registers in the cycle they are accepted; the NUL
//  byte loads the result register and returns the parse state to start of
//  string in that same edge. The result appears in the cycle after the NUL.
//  Reset (synchronous, active low) clears the parse state and the result valid.
//  i_char.ready drops only while a result is held and o_split.ready is low.
// ----------------------------------------------------------------------------
module host_port_string_splitter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    hpss_char_if.sink            i_char,
    hpss_split_if.source         o_split
);

    hpss_pkg::t_parse_state r_state, n_state;
    hpss_pkg::t_result      r_result;
    hpss_pkg::t_result      w_result;
    logic                   r_out_valid, n_out_valid;
    logic                   w_accept;
    logic                   w_is_nul;
    logic [7:0]             w_c;
    logic [hpss_pkg::POS_W-1:0] w_p;

    // Result register doubles as the skid: take a byte whenever it is free
    // or being emptied this cycle.
    assign i_char.ready = !r_out_valid || o_split.ready;
    assign w_accept     = i_char.valid && i_char.ready;
    assign w_c          = i_char.char_code;
    assign w_is_nul     = (w_c == hpss_pkg::CHR_NUL);
    assign w_p          = r_state.position;

    hpss_result u_result (
        .i_state  (r_state),
        .o_result (w_result)
    );

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !o_split.ready;

        if (w_accept && w_is_nul) begin
            n_out_valid = 1'b1;
            n_state     = '0;
            n_state.mode = hpss_pkg::MODE_START;
        end else if (w_accept) begin
            // position saturates at MAX_LEN; reaching it marks too long
            if (w_p >= hpss_pkg::POS_W'(hpss_pkg::MAX_LEN - 1)) begin
                n_state.too_long_flag = 1'b1;
                n_state.position      = hpss_pkg::POS_W'(hpss_pkg::MAX_LEN);
            end else begin
                n_state.position = w_p + hpss_pkg::POS_W'(1);
            end

            if (!(r_state.error_flag || n_state.too_long_flag)) begin
                case (r_state.mode)
                    hpss_pkg::MODE_START: begin
                        if (w_c == hpss_pkg::CHR_LBR) begin
                            n_state.mode = hpss_pkg::MODE_BR_HOST;
                        end else if (w_c == hpss_pkg::CHR_RBR) begin
                            n_state.error_flag = 1'b1;
                        end else begin
                            n_state.mode = hpss_pkg::MODE_PLAIN;
                            if (w_c == hpss_pkg::CHR_COLON) begin
                                n_state.colons_seen    = hpss_pkg::POS_W'(1);
                                n_state.last_colon_pos = w_p;
                            end
                        end
                    end
                    hpss_pkg::MODE_BR_HOST: begin
                        if (w_c == hpss_pkg::CHR_LBR) begin
                            n_state.error_flag = 1'b1;   // nested bracket
                        end else if (w_c == hpss_pkg::CHR_RBR) begin
                            if (w_p == hpss_pkg::POS_W'(1)) begin
                                n_state.error_flag = 1'b1;   // empty host
                            end else begin
                                n_state.close_bracket_pos = w_p;
                                n_state.mode = hpss_pkg::MODE_BR_AFTER;
                            end
                        end
                    end
                    hpss_pkg::MODE_BR_AFTER: begin
                        if (w_c == hpss_pkg::CHR_COLON) begin
                            n_state.mode = hpss_pkg::MODE_BR_COLON;
                        end else begin
                            n_state.error_flag = 1'b1;   // junk after ']'
                        end
                    end
                    hpss_pkg::MODE_BR_COLON, hpss_pkg::MODE_BR_PORT: begin
                        if (w_c == hpss_pkg::CHR_RBR) begin
                            n_state.error_flag = 1'b1;
                        end else begin
                            n_state.mode = hpss_pkg::MODE_BR_PORT;
                        end
                    end
                    default: begin
                        // plain host text
                        if (w_c == hpss_pkg::CHR_RBR) begin
                            n_state.error_flag = 1'b1;
                        end else if (w_c == hpss_pkg::CHR_COLON) begin
                            n_state.colons_seen    = r_state.colons_seen
                                                     + hpss_pkg::POS_W'(1);
                            n_state.last_colon_pos = w_p;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // all-zero state is start of string (MODE_START encodes as zero)
            r_state      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        if (w_accept && w_is_nul) begin
            r_result <= w_result;
        end
    end

    assign o_split.valid        = r_out_valid;
    assign o_split.status       = r_result.status;
    assign o_split.host_start   = r_result.host_start;
    assign o_split.host_len     = r_result.host_len;
    assign o_split.port_start   = r_result.port_start;
    assign o_split.port_len     = r_result.port_len;
    assign o_split.is_bracketed = r_result.is_bracketed;
    assign o_split.colon_count  = r_result.colon_count;

endmodule
